// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CMFR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A result held back by the receiver keeps the given signal steady.
`define CMFR_ASSERT_HOLD(name, vld, rdy, sig, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(sig))) else $error(msg);

`endif

// ===== design/cmfr_pkg.sv =====
package cmfr_pkg;

  localparam int HEAD_BITS        = 4;
  localparam int INDEX_BITS       = 8;
  localparam int HEAD_FIELD_W     = 4;
  localparam int INDEX_FIELD_W    = 8;
  localparam int HeadCmpBits      = (HEAD_BITS < HEAD_FIELD_W) ? HEAD_BITS : HEAD_FIELD_W;
  localparam int IdxCmpBits       = (INDEX_BITS < INDEX_FIELD_W) ? INDEX_BITS : INDEX_FIELD_W;
  localparam int BYTES_PER_FRAME  = 8;
  localparam int HEADER_SUM_BYTES = 4;
  localparam int QUEUE_DEPTH      = 2;
  localparam int ADDR_W           = 3;
  localparam int RegIdxBit        = 2;

  localparam logic [7:0] BROADCAST_ADDR = 8'h00;

  typedef enum logic {
    REG_EXPECTED_HEAD = 1'b0,
    REG_OWN_DEVICE    = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_BAD_HEAD     = 3'd0,
    ST_BAD_DEST     = 3'd1,
    ST_OUT_OF_SEQ   = 3'd2,
    ST_STARTED      = 3'd3,
    ST_PARTIAL      = 3'd4,
    ST_GOOD         = 3'd5,
    ST_BAD_CHECKSUM = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CLS_BAD_HEAD = 2'd0,
    CLS_BAD_DEST = 2'd1,
    CLS_FIRST    = 2'd2,
    CLS_CONT     = 2'd3
  } cls_e;

  typedef struct packed {
    cls_e                  cls;
    logic [7:0]            device;
    logic [7:0]            seq;
    logic [INDEX_BITS-1:0] fidx;
    logic [63:0]           data;
  } item_t;

endpackage

// ===== design/can_multiframe_reassembler.sv =====
// CAN multi-frame packet reassembler.
// Input channel (in_valid_i/in_ready_o): one received frame per item, given as
// identifier fields and eight data bytes. Output channel (out_valid_o/out_ready_i):
// exactly one result item per frame, with status, the forwarded payload chunk and
// the command, subcommand and length of the packet most recently started.
// The APB port sets the expected head value (offset 0) and this device's address
// (offset 4); write it only while no frame is in flight.
// A frame is written into the queue when accepted, and its result is loaded into the
// result register when the back stage takes the frame from the queue.
// One frame per cycle while the receiver takes results, set by the update of the packet
// state in the back stage.
// A two-entry queue sits between the classifying front and the back stage, and the
// result register is loaded whenever it is empty or being emptied. When the
// receiver stalls, the result holds, the queue fills and in_ready_o falls once both
// queue entries are taken.
// Reset clears the packet state, the queue and both configuration registers.
module can_multiframe_reassembler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cmfr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [3:0]                  id_head_i,
  input  logic [7:0]                  id_device_i,
  input  logic [7:0]                  id_packet_seq_i,
  input  logic [7:0]                  id_frame_index_i,
  input  logic [63:0]                 frame_bytes_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic [63:0]                 chunk_o,
  output logic [3:0]                  chunk_count_o,
  output logic [7:0]                  packet_cmd_o,
  output logic [7:0]                  packet_subcmd_o,
  output logic [15:0]                 packet_length_o
);
  import cmfr_pkg::*;

  logic [3:0] expected_head_q;
  logic [7:0] own_addr_q;
  logic       cfg_wr;
  reg_idx_e   reg_idx;

  logic       queue_full;
  logic       push;
  logic       pop;
  logic       q_valid;
  item_t      front_item;
  item_t      q_item;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[RegIdxBit]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_head_q <= '0;
      own_addr_q      <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_EXPECTED_HEAD: expected_head_q <= pwdata[3:0];
        REG_OWN_DEVICE:    own_addr_q      <= pwdata[7:0];
        default:           own_addr_q      <= own_addr_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_EXPECTED_HEAD: prdata = {28'd0, expected_head_q};
      REG_OWN_DEVICE:    prdata = {24'd0, own_addr_q};
      default:           prdata = '0;
    endcase
  end

  cmfr_front u_front (
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .id_head_i            (id_head_i),
    .id_device_i          (id_device_i),
    .id_packet_seq_i      (id_packet_seq_i),
    .id_frame_index_i     (id_frame_index_i),
    .frame_bytes_i        (frame_bytes_i),
    .expected_head_i      (expected_head_q),
    .own_device_address_i (own_addr_q),
    .queue_full_i         (queue_full),
    .push_o               (push),
    .item_o               (front_item)
  );

  cmfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  cmfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .item_i          (q_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .chunk_o         (chunk_o),
    .chunk_count_o   (chunk_count_o),
    .packet_cmd_o    (packet_cmd_o),
    .packet_subcmd_o (packet_subcmd_o),
    .packet_length_o (packet_length_o)
  );

endmodule

// ===== design/cmfr_front.sv =====
module cmfr_front (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        id_head_i,
  input  logic [7:0]        id_device_i,
  input  logic [7:0]        id_packet_seq_i,
  input  logic [7:0]        id_frame_index_i,
  input  logic [63:0]       frame_bytes_i,
  input  logic [3:0]        expected_head_i,
  input  logic [7:0]        own_device_address_i,
  input  logic              queue_full_i,
  output logic              push_o,
  output cmfr_pkg::item_t   item_o
);
  import cmfr_pkg::*;

  logic [INDEX_BITS-1:0] fidx;
  logic [7:0]            dest;
  logic                  head_ok;
  logic                  dest_ok;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  always_comb begin
    fidx    = INDEX_BITS'(id_frame_index_i[IdxCmpBits-1:0]);
    dest    = frame_bytes_i[7:0];
    head_ok = (id_head_i[HeadCmpBits-1:0] == expected_head_i[HeadCmpBits-1:0]);
    dest_ok = (dest == own_device_address_i) || (dest == BROADCAST_ADDR);

    item_o.device = id_device_i;
    item_o.seq    = id_packet_seq_i;
    item_o.fidx   = fidx;
    item_o.data   = frame_bytes_i;
    if (!head_ok) begin
      item_o.cls = CLS_BAD_HEAD;
    end else if (fidx == '0) begin
      item_o.cls = dest_ok ? CLS_FIRST : CLS_BAD_DEST;
    end else begin
      item_o.cls = CLS_CONT;
    end
  end

endmodule

// ===== design/cmfr_queue.sv =====
module cmfr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  cmfr_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output cmfr_pkg::item_t item_o
);
  import cmfr_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  item_t             mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== design/cmfr_back.sv =====
module cmfr_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  cmfr_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [2:0]      status_o,
  output logic [63:0]     chunk_o,
  output logic [3:0]      chunk_count_o,
  output logic [7:0]      packet_cmd_o,
  output logic [7:0]      packet_subcmd_o,
  output logic [15:0]     packet_length_o
);
  import cmfr_pkg::*;

  // Packet state.
  logic                  collecting_q, collecting_d;
  logic [7:0]            packet_seq_q, packet_seq_d;
  logic [INDEX_BITS-1:0] next_idx_q, next_idx_d;
  logic [7:0]            packet_dev_q, packet_dev_d;
  logic [15:0]           total_len_q, total_len_d;
  logic [15:0]           recv_len_q, recv_len_d;
  logic [15:0]           run_sum_q, run_sum_d;
  logic [15:0]           exp_sum_q, exp_sum_d;
  logic [15:0]           cmd_sub_q, cmd_sub_d;

  // Output register.
  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [63:0]           chunk_q, chunk_d;
  logic [3:0]            count_q, count_d;
  logic [15:0]           res_cmd_sub_q;
  logic [15:0]           res_len_q;

  logic [15:0]           remain;
  logic [15:0]           sum;
  logic [15:0]           recv_next;
  logic                  match;

  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    collecting_d = collecting_q;
    packet_seq_d = packet_seq_q;
    next_idx_d   = next_idx_q;
    packet_dev_d = packet_dev_q;
    total_len_d  = total_len_q;
    recv_len_d   = recv_len_q;
    run_sum_d    = run_sum_q;
    exp_sum_d    = exp_sum_q;
    cmd_sub_d    = cmd_sub_q;
    status_d     = ST_OUT_OF_SEQ;
    chunk_d      = '0;
    count_d      = '0;
    remain       = total_len_q - recv_len_q;
    sum          = '0;
    recv_next    = recv_len_q;
    match        = collecting_q && (item_i.seq == packet_seq_q) &&
                   (item_i.fidx == next_idx_q) && (item_i.device == packet_dev_q);

    case (item_i.cls)
      CLS_BAD_HEAD: begin
        status_d = ST_BAD_HEAD;
      end
      CLS_BAD_DEST: begin
        status_d = ST_BAD_DEST;
      end
      CLS_FIRST: begin
        // Header sum covers cmd, subcmd and both length bytes.
        for (int i = HEADER_SUM_BYTES; i < 2 * HEADER_SUM_BYTES; i++) begin
          sum = sum + 16'(item_i.data[8*i +: 8]);
        end
        exp_sum_d    = {item_i.data[23:16], item_i.data[31:24]};
        cmd_sub_d    = {item_i.data[39:32], item_i.data[47:40]};
        total_len_d  = {item_i.data[55:48], item_i.data[63:56]};
        recv_len_d   = '0;
        run_sum_d    = sum;
        packet_seq_d = item_i.seq;
        packet_dev_d = item_i.device;
        next_idx_d   = item_i.fidx + 1'b1;
        if (total_len_d == '0) begin
          collecting_d = 1'b0;
          status_d     = (sum == exp_sum_d) ? ST_GOOD : ST_BAD_CHECKSUM;
        end else begin
          collecting_d = 1'b1;
          status_d     = ST_STARTED;
        end
      end
      CLS_CONT: begin
        if (match) begin
          count_d = (remain >= 16'(BYTES_PER_FRAME)) ? 4'(BYTES_PER_FRAME) : remain[3:0];
          sum     = run_sum_q;
          for (int i = 0; i < BYTES_PER_FRAME; i++) begin
            if (4'(i) < count_d) begin
              chunk_d[8*i +: 8] = item_i.data[8*i +: 8];
              sum               = sum + 16'(item_i.data[8*i +: 8]);
            end
          end
          recv_next  = recv_len_q + 16'(count_d);
          run_sum_d  = sum;
          recv_len_d = recv_next;
          next_idx_d = item_i.fidx + 1'b1;
          if (recv_next == total_len_q) begin
            collecting_d = 1'b0;
            status_d     = (sum == exp_sum_q) ? ST_GOOD : ST_BAD_CHECKSUM;
          end else begin
            status_d = ST_PARTIAL;
          end
        end else begin
          status_d = ST_OUT_OF_SEQ;
        end
      end
      default: begin
        status_d = ST_OUT_OF_SEQ;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      packet_seq_q <= '0;
      next_idx_q   <= '0;
      packet_dev_q <= '0;
      total_len_q  <= '0;
      recv_len_q   <= '0;
      run_sum_q    <= '0;
      exp_sum_q    <= '0;
      cmd_sub_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        collecting_q <= collecting_d;
        packet_seq_q <= packet_seq_d;
        next_idx_q   <= next_idx_d;
        packet_dev_q <= packet_dev_d;
        total_len_q  <= total_len_d;
        recv_len_q   <= recv_len_d;
        run_sum_q    <= run_sum_d;
        exp_sum_q    <= exp_sum_d;
        cmd_sub_q    <= cmd_sub_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q      <= status_d;
      chunk_q       <= chunk_d;
      count_q       <= count_d;
      res_cmd_sub_q <= cmd_sub_d;
      res_len_q     <= total_len_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign chunk_o         = chunk_q;
  assign chunk_count_o   = count_q;
  assign packet_cmd_o    = res_cmd_sub_q[15:8];
  assign packet_subcmd_o = res_cmd_sub_q[7:0];
  assign packet_length_o = res_len_q;

endmodule

// ===== design/cmfr_checker.sv =====
`include "assert_macros.svh"

module cmfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [63:0] chunk_o,
  input logic [3:0]  chunk_count_o
);
  import cmfr_pkg::*;

  `CMFR_ASSERT_HOLD(a_result_holds, out_valid_o, out_ready_i, {status_o, chunk_o}, "result changed while stalled")

  `CMFR_ASSERT(a_status_range, out_valid_o |-> (status_o != 3'd7), "status code out of range")

  `CMFR_ASSERT(a_no_chunk_when_not_forwarding, out_valid_o && (status_o == ST_BAD_HEAD || status_o == ST_BAD_DEST || status_o == ST_OUT_OF_SEQ || status_o == ST_STARTED) |-> (chunk_count_o == 4'd0 && chunk_o == 64'd0), "chunk present on a frame that forwards nothing")

  `CMFR_ASSERT(a_partial_is_full_frame, out_valid_o && (status_o == ST_PARTIAL) |-> (chunk_count_o == 4'(BYTES_PER_FRAME)), "partial packet frame forwarded less than a full frame")

endmodule

bind can_multiframe_reassembler cmfr_checker u_cmfr_checker (.*);

// ===== test/reassembly_checker.sv =====
module reassembly_checker
  import cmfr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [3:0]        id_head_i,
  input  logic [7:0]        id_device_i,
  input  logic [7:0]        id_packet_seq_i,
  input  logic [7:0]        id_frame_index_i,
  input  logic [63:0]       frame_bytes_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [2:0]        status_i,
  input  logic [63:0]       chunk_i,
  input  logic [3:0]        chunk_count_i,
  input  logic [7:0]        packet_cmd_i,
  input  logic [7:0]        packet_subcmd_i,
  input  logic [15:0]       packet_length_i,
  output int                errors_o,
  output int                pending_o,
  output int                outcomes_o,
  output int                good_o,
  output int                bad_sum_o
);

  typedef struct packed {
    status_e     status;
    logic [63:0] chunk;
    logic [3:0]  count;
    logic [7:0]  cmd;
    logic [7:0]  subcmd;
    logic [15:0] length;
  } outcome_t;

  outcome_t pending_outcomes[$];

  // Configuration as seen on the register port.
  logic [3:0] cfg_head;
  logic [7:0] cfg_own;

  // Packet being collected.
  logic                  collecting;
  logic [7:0]            pkt_seq;
  logic [INDEX_BITS-1:0] next_idx;
  logic [7:0]            pkt_dev;
  logic [15:0]           total_len;
  logic [15:0]           rcvd_len;
  logic [15:0]           run_sum;
  logic [15:0]           exp_sum;
  logic [7:0]            pkt_cmd;
  logic [7:0]            pkt_sub;

  function automatic outcome_t reassemble_frame(input logic [3:0]  head,
                                                input logic [7:0]  dev,
                                                input logic [7:0]  seq,
                                                input logic [7:0]  idx_field,
                                                input logic [63:0] data);
    outcome_t              r;
    logic [INDEX_BITS-1:0] fidx;
    logic [7:0]            b;
    int                    remain;
    int                    n;
    r = '0;
    fidx = '0;
    fidx[IdxCmpBits-1:0] = idx_field[IdxCmpBits-1:0];
    if (head[HeadCmpBits-1:0] != cfg_head[HeadCmpBits-1:0]) begin
      r.status = ST_BAD_HEAD;
    end else if (fidx == '0) begin
      if (data[7:0] != cfg_own && data[7:0] != BROADCAST_ADDR) begin
        r.status = ST_BAD_DEST;
      end else begin
        exp_sum   = {data[23:16], data[31:24]};
        pkt_cmd   = data[39:32];
        pkt_sub   = data[47:40];
        total_len = {data[55:48], data[63:56]};
        rcvd_len  = '0;
        run_sum   = 16'(data[39:32]) + 16'(data[47:40]) + 16'(data[55:48]) +
                    16'(data[63:56]);
        pkt_seq   = seq;
        pkt_dev   = dev;
        next_idx  = fidx + 1'b1;
        if (total_len == '0) begin
          collecting = 1'b0;
          r.status   = (run_sum == exp_sum) ? ST_GOOD : ST_BAD_CHECKSUM;
        end else begin
          collecting = 1'b1;
          r.status   = ST_STARTED;
        end
      end
    end else if (collecting && seq == pkt_seq && fidx == next_idx && dev == pkt_dev) begin
      remain = int'(total_len - rcvd_len);
      n = (remain >= BYTES_PER_FRAME) ? BYTES_PER_FRAME : remain;
      for (int i = 0; i < n; i++) begin
        b = data[8*i +: 8];
        run_sum = run_sum + 16'(b);
        r.chunk[8*i +: 8] = b;
      end
      r.count  = 4'(n);
      rcvd_len = rcvd_len + 16'(n);
      next_idx = fidx + 1'b1;
      if (rcvd_len == total_len) begin
        collecting = 1'b0;
        r.status   = (run_sum == exp_sum) ? ST_GOOD : ST_BAD_CHECKSUM;
      end else begin
        r.status = ST_PARTIAL;
      end
    end else begin
      r.status = ST_OUT_OF_SEQ;
    end
    r.cmd    = pkt_cmd;
    r.subcmd = pkt_sub;
    r.length = total_len;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    outcome_t want;
    if (!rst_ni) begin
      pending_outcomes.delete();
      cfg_head   = '0;
      cfg_own    = '0;
      collecting = 1'b0;
      pkt_seq    = '0;
      next_idx   = '0;
      pkt_dev    = '0;
      total_len  = '0;
      rcvd_len   = '0;
      run_sum    = '0;
      exp_sum    = '0;
      pkt_cmd    = '0;
      pkt_sub    = '0;
      errors_o   = 0;
      pending_o  = 0;
      outcomes_o = 0;
      good_o     = 0;
      bad_sum_o  = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[RegIdxBit]))
          REG_EXPECTED_HEAD: cfg_head = pwdata_i[3:0];
          REG_OWN_DEVICE:    cfg_own  = pwdata_i[7:0];
          default: ;
        endcase
      end
      // A result never leaves in the cycle its frame is taken, so the
      // result side is handled before the frame side.
      if (out_valid_i && out_ready_i) begin
        if (pending_outcomes.size() == 0) begin
          $error("result item with no frame waiting for it");
          errors_o++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("status", 64'(want.status), 64'(status_i));
          check_field("chunk", want.chunk, chunk_i);
          check_field("chunk_count", 64'(want.count), 64'(chunk_count_i));
          check_field("packet_cmd", 64'(want.cmd), 64'(packet_cmd_i));
          check_field("packet_subcmd", 64'(want.subcmd), 64'(packet_subcmd_i));
          check_field("packet_length", 64'(want.length), 64'(packet_length_i));
        end
        outcomes_o++;
        if (status_i == ST_GOOD) good_o++;
        if (status_i == ST_BAD_CHECKSUM) bad_sum_o++;
      end
      if (in_valid_i && in_ready_i) begin
        pending_outcomes.push_back(reassemble_frame(id_head_i, id_device_i,
                                                    id_packet_seq_i, id_frame_index_i,
                                                    frame_bytes_i));
      end
      pending_o = pending_outcomes.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import cmfr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              psel             = 1'b0;
  logic              penable          = 1'b0;
  logic              pwrite           = 1'b0;
  logic [ADDR_W-1:0] paddr            = '0;
  logic [31:0]       pwdata           = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i       = 1'b0;
  logic              in_ready_o;
  logic [3:0]        id_head_i        = '0;
  logic [7:0]        id_device_i      = '0;
  logic [7:0]        id_packet_seq_i  = '0;
  logic [7:0]        id_frame_index_i = '0;
  logic [63:0]       frame_bytes_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i      = 1'b0;
  logic [2:0]        status_o;
  logic [63:0]       chunk_o;
  logic [3:0]        chunk_count_o;
  logic [7:0]        packet_cmd_o;
  logic [7:0]        packet_subcmd_o;
  logic [15:0]       packet_length_o;

  int mismatches;
  int pending;
  int outcomes;
  int good_packets;
  int bad_sums;

  int frames_sent     = 0;
  int cycles          = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int hold_left       = 0;
  bit hold_request    = 1'b0;
  bit hold_served     = 1'b0;

  logic [3:0] cur_head = '0;
  logic [7:0] cur_own  = '0;

  can_multiframe_reassembler DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .id_head_i        (id_head_i),
    .id_device_i      (id_device_i),
    .id_packet_seq_i  (id_packet_seq_i),
    .id_frame_index_i (id_frame_index_i),
    .frame_bytes_i    (frame_bytes_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .chunk_o          (chunk_o),
    .chunk_count_o    (chunk_count_o),
    .packet_cmd_o     (packet_cmd_o),
    .packet_subcmd_o  (packet_subcmd_o),
    .packet_length_o  (packet_length_o)
  );

  reassembly_checker reassembly_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .id_head_i        (id_head_i),
    .id_device_i      (id_device_i),
    .id_packet_seq_i  (id_packet_seq_i),
    .id_frame_index_i (id_frame_index_i),
    .frame_bytes_i    (frame_bytes_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_i         (status_o),
    .chunk_i          (chunk_o),
    .chunk_count_i    (chunk_count_o),
    .packet_cmd_i     (packet_cmd_o),
    .packet_subcmd_i  (packet_subcmd_o),
    .packet_length_i  (packet_length_o),
    .errors_o         (mismatches),
    .pending_o        (pending),
    .outcomes_o       (outcomes),
    .good_o           (good_packets),
    .bad_sum_o        (bad_sums)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  initial begin : watchdog
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still owed", cycles, pending);
    $display("tb_top: FAIL");
    $finish;
  end

  // The receiver serves one long hold-off when asked, so that the block
  // fills up and pushes back on the sender.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_served) begin
      out_ready_i <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_served <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic offer(input logic [3:0] head, input logic [7:0] dev,
                       input logic [7:0] seq, input logic [7:0] idx,
                       input logic [63:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    id_head_i        <= head;
    id_device_i      <= dev;
    id_packet_seq_i  <= seq;
    id_frame_index_i <= idx;
    frame_bytes_i    <= data;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    frames_sent++;
  endtask

  function automatic logic [63:0] first_frame(input logic [7:0] dest,
                                              input logic [7:0] cmd,
                                              input logic [7:0] subcmd,
                                              input logic [15:0] len,
                                              input logic [15:0] chk);
    return {len[7:0], len[15:8], subcmd, cmd, chk[7:0], chk[15:8], 8'($urandom), dest};
  endfunction

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << RegIdxBit;
    pwdata  <= {24'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic configure(input logic [3:0] head, input logic [7:0] own);
    write_reg(REG_EXPECTED_HEAD, {4'($urandom), head});
    write_reg(REG_OWN_DEVICE, own);
    cur_head = head;
    cur_own  = own;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // A frame from outside the packet: mostly a foreign head, a foreign
  // packet or a rejected first frame.
  task automatic stray_frame();
    logic [3:0] head;
    head = $urandom_range(1) ? cur_head : 4'($urandom);
    offer(head, 8'($urandom), 8'($urandom),
          ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom), {$urandom, $urandom});
  endtask

  task automatic send_packet(input int len, input bit sum_ok, input bit cut_short);
    logic [7:0]  body[$];
    logic [7:0]  dev;
    logic [7:0]  seq;
    logic [7:0]  cmd;
    logic [7:0]  subcmd;
    logic [15:0] plen;
    logic [15:0] sum;
    logic [15:0] chk;
    logic [63:0] data;
    int          frames;
    body   = {};
    dev    = 8'($urandom);
    seq    = 8'($urandom);
    cmd    = 8'($urandom);
    subcmd = 8'($urandom);
    plen   = 16'(len);
    sum    = 16'(cmd) + 16'(subcmd) + 16'(plen[15:8]) + 16'(plen[7:0]);
    for (int i = 0; i < len; i++) begin
      body.push_back(8'($urandom));
      sum = sum + 16'(body[i]);
    end
    chk = sum_ok ? sum : sum + 16'($urandom_range(1, 65535));
    offer(cur_head, dev, seq, 8'h00,
          first_frame($urandom_range(1) ? cur_own : BROADCAST_ADDR, cmd, subcmd, plen, chk));
    frames = (len + 7) / 8;
    if (cut_short && frames > 0) frames = $urandom_range(frames - 1);
    for (int k = 1; k <= frames; k++) begin
      if ($urandom_range(99) < 8) begin
        // Either a skipped index within this packet or an unrelated frame.
        if ($urandom_range(1)) offer(cur_head, dev, seq, 8'(k + 1), {$urandom, $urandom});
        else stray_frame();
      end
      data = {$urandom, $urandom};
      for (int i = 0; i < 8; i++) begin
        if ((k - 1) * 8 + i < len) data[8*i +: 8] = body[(k - 1) * 8 + i];
      end
      offer(cur_head, dev, seq, 8'(k), data);
    end
  endtask

  task automatic run_random(input int budget, input bit with_long);
    int stop;
    int roll;
    int len;
    logic [7:0] cmd;
    logic [7:0] subcmd;
    stop = frames_sent + budget;
    // A packet this long can run the frame index past its wrap.
    if (with_long) send_packet($urandom_range(2040, 2100), 1'b1, 1'b0);
    while (frames_sent < stop) begin
      roll = $urandom_range(99);
      if (roll < 72) begin
        roll = $urandom_range(99);
        if (roll < 10) len = 0;
        else if (roll < 55) len = $urandom_range(1, 24);
        else if (roll < 85) len = $urandom_range(25, 100);
        else len = $urandom_range(101, 300);
        send_packet(len, $urandom_range(99) < 75, $urandom_range(99) < 12);
      end else if (roll < 88) begin
        stray_frame();
      end else begin
        // Lone first frame: empty packet or a foreign destination.
        cmd    = 8'($urandom);
        subcmd = 8'($urandom);
        offer(cur_head, 8'($urandom), 8'($urandom), 8'h00,
              first_frame($urandom_range(1) ? cur_own : 8'($urandom), cmd, subcmd, 16'd0,
                          $urandom_range(1) ? 16'(cmd) + 16'(subcmd) : 16'($urandom)));
      end
    end
  endtask

  initial begin : stimulus
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    configure(4'h5, 8'h3C);
    offer(4'h4, 8'hA1, 8'h07, 8'h00, first_frame(8'h3C, 8'h01, 8'h02, 16'd13, 16'h006B));
    offer(4'hF, 8'hFF, 8'hFF, 8'hFF, '1);
    // All-zero first frame: broadcast, empty, and its checksum of zero holds.
    offer(4'h5, 8'h00, 8'h00, 8'h00, '0);
    offer(4'h5, 8'hA1, 8'h07, 8'h00, first_frame(8'h3D, 8'h01, 8'h02, 16'd13, 16'h006B));
    offer(4'h5, 8'hA1, 8'h07, 8'h01, {$urandom, $urandom});
    offer(4'h5, 8'h10, 8'h20, 8'h00, first_frame(8'h3C, 8'h12, 8'h34, 16'd0, 16'h0046));
    offer(4'h5, 8'h10, 8'h21, 8'h00, first_frame(8'h00, 8'h12, 8'h34, 16'd0, 16'h0047));
    offer(4'h5, 8'h00, 8'hFF, 8'h00, first_frame(8'h00, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF));
    // Restart while the longest packet is still open.
    offer(4'h5, 8'hA1, 8'h07, 8'h00, first_frame(8'h3C, 8'h01, 8'h02, 16'd13, 16'h006B));
    offer(4'h5, 8'hA1, 8'h08, 8'h01, {$urandom, $urandom});
    offer(4'h5, 8'hA2, 8'h07, 8'h01, {$urandom, $urandom});
    offer(4'h5, 8'hA1, 8'h07, 8'h02, {$urandom, $urandom});
    offer(4'h5, 8'hA1, 8'h07, 8'h01, 64'h0807_0605_0403_0201);
    offer(4'hD, 8'hA1, 8'h07, 8'h02, {$urandom, $urandom});
    offer(4'h5, 8'hA1, 8'h07, 8'h02, 64'hFFFF_FF0D_0C0B_0A09);
    offer(4'h5, 8'hA1, 8'h07, 8'h03, {$urandom, $urandom});
    offer(4'h5, 8'h33, 8'h44, 8'h00, first_frame(8'h3C, 8'h80, 8'h7F, 16'd3, 16'h0000));
    offer(4'h5, 8'h33, 8'h44, 8'h01, 64'hFFFF_FFFF_FF01_0203);
    drain();

    configure(4'hF, 8'hFF);
    run_random(400, 1'b1);
    drain();

    configure(4'h0, 8'h00);
    sender_idle_pct = 62;
    run_random(400, 1'b0);
    drain();

    configure(4'($urandom), 8'($urandom));
    sender_idle_pct = 0;
    recv_stall_pct  = 62;
    run_random(400, 1'b0);
    drain();

    configure(4'($urandom), 8'($urandom));
    sender_idle_pct = 38;
    recv_stall_pct  = 38;
    run_random(400, 1'b0);
    drain();

    configure(4'h9, 8'h81);
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = 1'b1;
    run_random(400, 1'b0);
    drain();

    $display("%0d frames under 6 register settings, %0d results checked",
             frames_sent, outcomes);
    $display("%0d packets closed good, %0d with a checksum error, %0d mismatches",
             good_packets, bad_sums, mismatches);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/cmfr_pkg.sv
design/cmfr_front.sv
design/cmfr_queue.sv
design/cmfr_back.sv
design/can_multiframe_reassembler.sv
design/cmfr_checker.sv
test/reassembly_checker.sv
test/tb_top.sv
